FILE: hdl/ostpf_pkg.sv
package ostpf_pkg;

  localparam int CHANNEL_COUNT  = 32;
  localparam int CHANNEL_STRIDE = 256;
  localparam int TIMESTAMP_MASK = 8;

  localparam logic [7:0]  TYPE_DATA   = 8'h98;
  localparam logic [7:0]  TYPE_FLAG   = 8'hE8;
  localparam logic [7:0]  OPT_MARKED  = 8'h10;
  localparam logic [7:0]  START_TOKEN = 8'h30;
  localparam logic [7:0]  OST_VER     = 8'h01;
  localparam logic [31:0] SIZE_LIMIT  = 32'h0100_0000;
  localparam logic [7:0]  TS_CLEAR    = ~8'(TIMESTAMP_MASK);

  localparam int RES_MAX    = 3;
  localparam int RES_CNT_W  = $clog2(RES_MAX + 1);
  localparam int FIFO_DEPTH = 4;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  localparam logic [2:0] ADDR_TRACE_ENABLE = 3'h0;
  localparam logic [2:0] ADDR_ENTITY_MASK  = 3'h4;

  typedef struct packed {
    logic        trace_enable;
    logic [7:0]  entity_mask;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [4:0]  channel;
    logic [7:0]  options;
    logic [7:0]  ent_id;
    logic [7:0]  prot_id;
    logic [31:0] pkt_size;
    logic [2:0]  align_offset;
    logic [7:0]  data_byte;
  } beat_t;

  typedef struct packed {
    logic        write_enable;
    logic [12:0] write_offset;
    logic [63:0] write_data;
    logic        packet_last;
    logic        status;
    logic [24:0] bytes_sent;
  } res_t;

  function automatic logic [12:0] chan_offset(logic [4:0] ch, logic [7:0] ty,
                                              logic [7:0] opts);
    logic [31:0] base;
    base = 32'(ch) * CHANNEL_STRIDE;
    return base[12:0] | {5'b0, ty & ~opts};
  endfunction

endpackage

FILE: hdl/ostpf_core.sv
module ostpf_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ostpf_pkg::cfg_t                     cfg_i,
  input  logic                                step_i,
  input  ostpf_pkg::beat_t                    beat_i,
  output ostpf_pkg::res_t [ostpf_pkg::RES_MAX-1:0] res_o,
  output logic [ostpf_pkg::RES_CNT_W-1:0]     res_cnt_o
);

  localparam int RES_CNT_W = ostpf_pkg::RES_CNT_W;

  logic        in_pkt_q, in_pkt_d;
  logic [23:0] left_q, left_d;
  logic [2:0]  lane_q, lane_d;
  logic [63:0] buf_q, buf_d;
  logic [4:0]  chan_q, chan_d;
  logic [7:0]  opts_q, opts_d;
  logic [24:0] total_q, total_d;

  logic        accept_ok;
  logic [24:0] total_new;
  logic [63:0] hdr;
  logic [63:0] buf_nx;
  logic [2:0]  lane_nx;
  logic [23:0] left_nx;

  ostpf_pkg::res_t tail_new, tail_cur;

  always_comb begin
    accept_ok = cfg_i.trace_enable && ((cfg_i.entity_mask & beat_i.ent_id) != 8'h00) &&
                (beat_i.pkt_size < ostpf_pkg::SIZE_LIMIT) &&
                (32'(beat_i.channel) < ostpf_pkg::CHANNEL_COUNT);
    total_new = 25'd16 + ((25'(beat_i.pkt_size[23:0]) + 25'(beat_i.align_offset) +
                25'd7) & ~25'd7);
    hdr = {5'b0, beat_i.align_offset, beat_i.pkt_size[23:0], beat_i.prot_id,
           beat_i.ent_id, ostpf_pkg::OST_VER, ostpf_pkg::START_TOKEN};
    buf_nx = buf_q;
    for (int i = 0; i < 8; i++) begin
      if (lane_q == 3'(i)) begin
        buf_nx[i*8 +: 8] = buf_q[i*8 +: 8] | beat_i.data_byte;
      end
    end
    lane_nx = lane_q + 3'd1;
    left_nx = left_q - 24'd1;

    tail_new = '{write_enable: 1'b1,
                 write_offset: ostpf_pkg::chan_offset(beat_i.channel, ostpf_pkg::TYPE_FLAG,
                                                      beat_i.options),
                 write_data: 64'd0, packet_last: 1'b1, status: 1'b0,
                 bytes_sent: total_new};
    tail_cur = '{write_enable: 1'b1,
                 write_offset: ostpf_pkg::chan_offset(chan_q, ostpf_pkg::TYPE_FLAG, opts_q),
                 write_data: 64'd0, packet_last: 1'b1, status: 1'b0,
                 bytes_sent: total_q};
  end

  always_comb begin
    in_pkt_d  = in_pkt_q;
    left_d    = left_q;
    lane_d    = lane_q;
    buf_d     = buf_q;
    chan_d    = chan_q;
    opts_d    = opts_q;
    total_d   = total_q;
    res_o     = '0;
    res_cnt_o = '0;
    if (step_i) begin
      if (beat_i.action == ostpf_pkg::ACT_BEGIN) begin
        in_pkt_d = 1'b0;
        if (!accept_ok) begin
          res_o[0].packet_last = 1'b1;
          res_o[0].status      = 1'b1;
          res_cnt_o            = RES_CNT_W'(1);
        end else begin
          chan_d  = beat_i.channel;
          opts_d  = beat_i.options;
          total_d = total_new;
          res_o[0].write_enable = 1'b1;
          res_o[0].write_offset = ostpf_pkg::chan_offset(beat_i.channel,
              ostpf_pkg::TYPE_DATA,
              (beat_i.options | ostpf_pkg::OPT_MARKED) & ostpf_pkg::TS_CLEAR);
          res_o[0].write_data   = hdr;
          if (beat_i.pkt_size[23:0] == 24'd0) begin
            if (beat_i.align_offset != 3'd0) begin
              res_o[1].write_enable = 1'b1;
              res_o[1].write_offset = ostpf_pkg::chan_offset(beat_i.channel,
                  ostpf_pkg::TYPE_DATA, beat_i.options & ostpf_pkg::TS_CLEAR);
              res_o[2]  = tail_new;
              res_cnt_o = RES_CNT_W'(3);
            end else begin
              res_o[1]  = tail_new;
              res_cnt_o = RES_CNT_W'(2);
            end
          end else begin
            in_pkt_d  = 1'b1;
            left_d    = beat_i.pkt_size[23:0];
            lane_d    = beat_i.align_offset;
            buf_d     = 64'd0;
            res_cnt_o = RES_CNT_W'(1);
          end
        end
      end else if (in_pkt_q) begin
        buf_d  = buf_nx;
        lane_d = lane_nx;
        left_d = left_nx;
        if (lane_nx == 3'd0 || left_nx == 24'd0) begin
          res_o[0].write_enable = 1'b1;
          res_o[0].write_offset = ostpf_pkg::chan_offset(chan_q, ostpf_pkg::TYPE_DATA,
                                                         opts_q & ostpf_pkg::TS_CLEAR);
          res_o[0].write_data   = buf_nx;
          res_cnt_o             = RES_CNT_W'(1);
          buf_d                 = 64'd0;
        end
        if (left_nx == 24'd0) begin
          res_o[1]  = tail_cur;
          res_cnt_o = RES_CNT_W'(2);
          in_pkt_d  = 1'b0;
          lane_d    = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      left_q   <= 24'd0;
      lane_q   <= 3'd0;
    end else begin
      in_pkt_q <= in_pkt_d;
      left_q   <= left_d;
      lane_q   <= lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    chan_q  <= chan_d;
    opts_q  <= opts_d;
    total_q <= total_d;
  end

  a_open_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pkt_q |-> left_q != 24'd0)
    else $error("open packet with no bytes left");

  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_o != '0 && res_o[0].status) |-> (res_cnt_o == RES_CNT_W'(1) &&
                                              !res_o[0].write_enable))
    else $error("drop status mixed with writes");

endmodule

FILE: hdl/ostpf_fifo.sv
module ostpf_fifo (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [ostpf_pkg::RES_CNT_W-1:0]          push_cnt_i,
  input  ostpf_pkg::res_t [ostpf_pkg::RES_MAX-1:0] push_data_i,
  output logic                                     room_o,
  output logic                                     valid_o,
  input  logic                                     pop_i,
  output ostpf_pkg::res_t                          data_o
);

  localparam int PTR_W = $clog2(ostpf_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(ostpf_pkg::FIFO_DEPTH + 1);

  ostpf_pkg::res_t mem_q [ostpf_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop      = pop_i && valid_o;
  assign valid_o  = cnt_q != '0;
  assign room_o   = cnt_q <= CNT_W'(ostpf_pkg::FIFO_DEPTH - ostpf_pkg::RES_MAX);
  assign data_o   = mem_q[rd_ptr_q];
  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign cnt_d    = cnt_q + CNT_W'(push_cnt_i) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ostpf_pkg::RES_MAX; k++) begin
      if (ostpf_pkg::RES_CNT_W'(k) < push_cnt_i) begin
        mem_q[wr_ptr_q + PTR_W'(k)] <= push_data_i[k];
      end
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(ostpf_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != '0 |-> room_o)
    else $error("results pushed without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == cnt_q[PTR_W-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

FILE: hdl/ost_trace_packet_framer_unit.sv
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid_i/tready_o       tdata 72b, tuser 1b (action)
// m_axis   out  m_axis_tvalid_o/tready_i       tdata 104b, tuser 2b, tlast
// apb      in   psel/penable/pwrite, pready=1  two registers at 0x0 and 0x4
//
// One input beat per cycle while s_axis_tready_o is high; its zero to three
// results enter a four-entry result queue at the accepting edge and leave one
// per cycle while m_axis_tready_i is high. s_axis_tready_o drops while more than
// one result is queued: a two-result beat (last payload byte, empty payload) or a
// three-result beat (empty payload, prepad) stalls input, as does a stalled master.
// Reset empties the queue, closes any open packet, disables tracing, mask all ones.
module ost_trace_packet_framer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // channel, options, ent_id, prot_id, pkt_size, align_offset, data_byte
  input  logic [71:0]   s_axis_tdata_i,
  // action
  input  logic [0:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // write_offset, write_data, bytes_sent, 2 zero bits
  output logic [103:0]  m_axis_tdata_o,
  // write_enable, status
  output logic [1:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  ostpf_pkg::cfg_t  cfg_q, cfg_d;
  ostpf_pkg::beat_t beat;
  ostpf_pkg::res_t  res_out;
  ostpf_pkg::res_t [ostpf_pkg::RES_MAX-1:0] res;
  logic [ostpf_pkg::RES_CNT_W-1:0] res_cnt;
  logic step;
  logic room;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr)
        ostpf_pkg::ADDR_TRACE_ENABLE: cfg_d.trace_enable = pwdata[0];
        ostpf_pkg::ADDR_ENTITY_MASK:  cfg_d.entity_mask  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ostpf_pkg::ADDR_TRACE_ENABLE: prdata = {31'd0, cfg_q.trace_enable};
      ostpf_pkg::ADDR_ENTITY_MASK:  prdata = {24'd0, cfg_q.entity_mask};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trace_enable <= 1'b0;
      cfg_q.entity_mask  <= 8'hFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    beat.action       = s_axis_tuser_i[0];
    beat.channel      = s_axis_tdata_i[4:0];
    beat.options      = s_axis_tdata_i[12:5];
    beat.ent_id       = s_axis_tdata_i[20:13];
    beat.prot_id      = s_axis_tdata_i[28:21];
    beat.pkt_size     = s_axis_tdata_i[60:29];
    beat.align_offset = s_axis_tdata_i[63:61];
    beat.data_byte    = s_axis_tdata_i[71:64];
  end

  assign s_axis_tready_o = room;
  assign step            = s_axis_tvalid_i && room;

  ostpf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (step),
    .beat_i    (beat),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  ostpf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_data_i (res),
    .room_o      (room),
    .valid_o     (m_axis_tvalid_o),
    .pop_i       (m_axis_tready_i),
    .data_o      (res_out)
  );

  assign m_axis_tdata_o = {2'b00, res_out.bytes_sent, res_out.write_data,
                           res_out.write_offset};
  assign m_axis_tuser_o = {res_out.status, res_out.write_enable};
  assign m_axis_tlast_o = res_out.packet_last;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_MAX = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // channel, options, ent_id, prot_id, pkt_size, align_offset, data_byte
  logic [71:0] s_axis_tdata_i = '0;
  // action
  logic [0:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // write_offset, write_data, bytes_sent, 2 zero bits
  logic [103:0] m_axis_tdata_o;
  // write_enable, status
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ost_trace_packet_framer_unit dut (.*);

  always #CLK_HALF clk_i = ~clk_i;

  logic cfg_enable = 1'b0;
  logic [7:0] cfg_mask = 8'hFF;
  logic pk_open = 1'b0;
  logic [23:0] pk_left = '0;
  logic [2:0] pk_lane = '0;
  logic [63:0] pk_word = '0;
  logic [4:0] pk_chan = '0;
  logic [7:0] pk_opts = '0;
  logic [24:0] pk_total = '0;

  ostpf_pkg::res_t expected_writes[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int src_gap_max = 11;
  int snk_gap_max = 11;
  int sink_hold = 0;

  function automatic logic [12:0] write_addr(logic [4:0] ch, logic [7:0] ty,
                                             logic [7:0] clr);
    return {ch, 8'h00} | {5'b0, ty & ~clr};
  endfunction

  function automatic ostpf_pkg::res_t make_res(logic we, logic [12:0] off,
                                               logic [63:0] data, logic last,
                                               logic st, logic [24:0] sent);
    ostpf_pkg::res_t r;
    r.write_enable = we;
    r.write_offset = off;
    r.write_data = data;
    r.packet_last = last;
    r.status = st;
    r.bytes_sent = sent;
    return r;
  endfunction

  task automatic frame_predict(input ostpf_pkg::beat_t b);
    logic [63:0] hdr;
    logic [31:0] total;
    if (b.action == ostpf_pkg::ACT_BEGIN) begin
      pk_open = 1'b0;
      if (!(cfg_enable && (cfg_mask & b.ent_id) != 8'h00 &&
            b.pkt_size < ostpf_pkg::SIZE_LIMIT &&
            32'(b.channel) < ostpf_pkg::CHANNEL_COUNT)) begin
        expected_writes.push_back(make_res(1'b0, '0, '0, 1'b1, 1'b1, '0));
      end else begin
        pk_chan = b.channel;
        pk_opts = b.options;
        total = 32'd16 + ((b.pkt_size + 32'(b.align_offset) + 32'd7) & ~32'd7);
        pk_total = total[24:0];
        hdr = {(32'(b.align_offset) << 24) | b.pkt_size, b.prot_id, b.ent_id,
               ostpf_pkg::OST_VER, ostpf_pkg::START_TOKEN};
        expected_writes.push_back(make_res(1'b1,
          write_addr(b.channel, ostpf_pkg::TYPE_DATA,
                     (b.options | ostpf_pkg::OPT_MARKED) & ostpf_pkg::TS_CLEAR),
          hdr, 1'b0, 1'b0, '0));
        if (b.pkt_size == 32'd0) begin
          if (b.align_offset != 3'd0)
            expected_writes.push_back(make_res(1'b1,
              write_addr(b.channel, ostpf_pkg::TYPE_DATA, b.options & ostpf_pkg::TS_CLEAR),
              '0, 1'b0, 1'b0, '0));
          expected_writes.push_back(make_res(1'b1,
            write_addr(b.channel, ostpf_pkg::TYPE_FLAG, b.options), '0, 1'b1, 1'b0,
            pk_total));
        end else begin
          pk_open = 1'b1;
          pk_left = b.pkt_size[23:0];
          pk_lane = b.align_offset;
          pk_word = '0;
        end
      end
    end else if (pk_open) begin
      pk_word |= 64'(b.data_byte) << (8 * pk_lane);
      pk_lane = pk_lane + 3'd1;
      pk_left = pk_left - 24'd1;
      if (pk_lane == 3'd0 || pk_left == 24'd0) begin
        expected_writes.push_back(make_res(1'b1,
          write_addr(pk_chan, ostpf_pkg::TYPE_DATA, pk_opts & ostpf_pkg::TS_CLEAR),
          pk_word, 1'b0, 1'b0, '0));
        pk_word = '0;
      end
      if (pk_left == 24'd0) begin
        expected_writes.push_back(make_res(1'b1,
          write_addr(pk_chan, ostpf_pkg::TYPE_FLAG, pk_opts), '0, 1'b1, 1'b0, pk_total));
        pk_open = 1'b0;
        pk_lane = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input ostpf_pkg::res_t want,
                                 input ostpf_pkg::res_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%s: exp we=%0b off=%h data=%h last=%0b st=%0b sent=%0d",
               what, want.write_enable, want.write_offset, want.write_data,
               want.packet_last, want.status, want.bytes_sent);
      $display("%s: got we=%0b off=%h data=%h last=%0b st=%0b sent=%0d",
               what, got.write_enable, got.write_offset, got.write_data,
               got.packet_last, got.status, got.bytes_sent);
    end
  endtask

  always @(posedge clk_i) begin
    ostpf_pkg::res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sink_hold = $urandom_range(0, snk_gap_max);
      got = make_res(m_axis_tuser_o[0], m_axis_tdata_o[12:0], m_axis_tdata_o[76:13],
                     m_axis_tlast_o, m_axis_tuser_o[1], m_axis_tdata_o[101:77]);
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected beat", '0, got);
      end else begin
        want = expected_writes.pop_front();
        if (got !== want) report_mismatch("mismatch", want, got);
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_beat(input ostpf_pkg::beat_t b);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {b.data_byte, b.align_offset, b.pkt_size, b.prot_id,
                       b.ent_id, b.options, b.channel};
    s_axis_tuser_i <= b.action;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
    frame_predict(b);
    @(negedge clk_i);
  endtask

  function automatic ostpf_pkg::beat_t random_beat();
    ostpf_pkg::beat_t b;
    b.action = ostpf_pkg::ACT_BYTE;
    b.channel = 5'($urandom());
    b.options = 8'($urandom());
    b.ent_id = 8'($urandom());
    b.prot_id = 8'($urandom());
    b.pkt_size = $urandom();
    b.align_offset = 3'($urandom());
    b.data_byte = 8'($urandom());
    return b;
  endfunction

  task automatic send_packet(input logic [4:0] ch, input logic [7:0] opts,
                             input logic [7:0] ent, input logic [7:0] proto,
                             input logic [31:0] size, input logic [2:0] align,
                             input int nbytes);
    ostpf_pkg::beat_t b;
    b = random_beat();
    b.action = ostpf_pkg::ACT_BEGIN;
    b.channel = ch;
    b.options = opts;
    b.ent_id = ent;
    b.prot_id = proto;
    b.pkt_size = size;
    b.align_offset = align;
    send_beat(b);
    repeat (nbytes) send_beat(random_beat());
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ostpf_pkg::ADDR_TRACE_ENABLE) cfg_enable = data[0];
    else if (addr == ostpf_pkg::ADDR_ENTITY_MASK) cfg_mask = data[7:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_disabled_after_reset();
    send_packet(5'd3, 8'h00, 8'h01, 8'h22, 32'd4, 3'd0, 2);
    wait_idle();
  endtask

  task automatic test_directed_packets();
    apb_write(ostpf_pkg::ADDR_TRACE_ENABLE, 32'd1);
    send_packet(5'd0, 8'h00, 8'hFF, 8'h00, 32'd0, 3'd0, 0);
    send_packet(5'd31, 8'hFF, 8'h01, 8'hFF, 32'd0, 3'd7, 0);
    send_packet(5'd5, 8'h08, 8'h80, 8'hA5, 32'd1, 3'd7, 1);
    send_packet(5'd17, 8'h10, 8'h7F, 8'h5A, 32'd9, 3'd3, 9);
    // abandon an open packet with a fresh begin
    send_packet(5'd9, 8'hE7, 8'h44, 8'h3C, 32'h00FF_FFFF, 3'd0, 2);
    send_packet(5'd1, 8'h00, 8'h01, 8'h01, ostpf_pkg::SIZE_LIMIT, 3'd0, 0);
    send_packet(5'd2, 8'h00, 8'h01, 8'h01, 32'hFFFF_FFFF, 3'd5, 0);
    wait_idle();
  endtask

  task automatic test_mask_and_enable();
    apb_write(ostpf_pkg::ADDR_ENTITY_MASK, 32'h00);
    send_packet(5'd4, 8'h00, 8'hFF, 8'h11, 32'd2, 3'd1, 0);
    wait_idle();
    apb_write(ostpf_pkg::ADDR_ENTITY_MASK, 32'h0F);
    send_packet(5'd6, 8'h00, 8'hF0, 8'h11, 32'd2, 3'd1, 0);
    send_packet(5'd7, 8'h02, 8'h01, 8'h12, 32'd2, 3'd6, 2);
    wait_idle();
    apb_write(ostpf_pkg::ADDR_TRACE_ENABLE, 32'd0);
    send_packet(5'd8, 8'h00, 8'hFF, 8'h13, 32'd0, 3'd0, 0);
    wait_idle();
    apb_write(ostpf_pkg::ADDR_TRACE_ENABLE, 32'd1);
    apb_write(ostpf_pkg::ADDR_ENTITY_MASK, 32'hFF);
  endtask

  task automatic test_random_traffic(input int target, input logic [7:0] mask,
                                     input int gap_max);
    int stop_at, pick, nbytes;
    logic [31:0] size;
    ostpf_pkg::beat_t b;
    apb_write(ostpf_pkg::ADDR_ENTITY_MASK, 32'(mask));
    src_gap_max = gap_max;
    snk_gap_max = gap_max;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_beat(random_beat());
      end else if (pick < 18) begin
        b = random_beat();
        send_packet(b.channel, b.options, b.ent_id, b.prot_id,
                    $urandom() | ostpf_pkg::SIZE_LIMIT, b.align_offset, 0);
      end else begin
        b = random_beat();
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) : $urandom_range(0, 20);
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, size) : size;
        send_packet(b.channel, b.options, b.ent_id, b.prot_id, size,
                    b.align_offset, nbytes);
      end
    end
    wait_idle();
    src_gap_max = 11;
    snk_gap_max = 11;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_disabled_after_reset();
    test_directed_packets();
    test_mask_and_enable();
    test_random_traffic(100, 8'hFF, 11);
    test_random_traffic(95, 8'h5A, 11);
    test_random_traffic(95, 8'h81, 0);
    test_random_traffic(90, 8'hFF, 11);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ostpf_pkg.sv
hdl/ostpf_core.sv
hdl/ostpf_fifo.sv
hdl/ost_trace_packet_framer_unit.sv
sim/testbench.sv
